@@ hw/rtl/rc4_stream_cipher_assert.svh @@
// Assertion macros shared by the RC4 cipher modules.
// Expects aclk and aresetn in the scope of the including module.
`ifndef RC4_STREAM_CIPHER_ASSERT_SVH
`define RC4_STREAM_CIPHER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define RC4_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define RC4_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/rc4_pkg.sv @@
// Shared types, microcode encoding and control ROM for the RC4 cipher.
// No dependencies; used by rc4_seq, rc4_dp and rc4_stream_cipher.
package rc4_pkg;

    localparam int MAX_KEY_BYTES_DEF = 256;
    localparam int KEY_CNT_W         = 9;

    typedef struct packed {
        logic       func;
        logic [7:0] byte_in;
        logic       key_last;
    } rc4_in_t;

    typedef struct packed {
        logic [7:0] byte_out;
        logic       not_keyed;
    } rc4_out_t;

    localparam logic FUNC_KEY  = 1'b0;
    localparam logic FUNC_DATA = 1'b1;

    // Microprogram step addresses
    typedef enum logic [3:0] {
        U_IDLE, U_P1, U_P2, U_P3, U_P4, U_P5, U_PASS,
        U_K0, U_K1, U_K2, U_K3, U_K4, U_K5
    } upc_t;

    typedef enum logic [2:0] {
        J_NEXT, J_GOTO, J_DISPATCH, J_LOOP, J_WAIT_OUT
    } jmp_t;

    // S-box address select
    typedef enum logic [2:0] {
        SA_I_PLUS1, SA_J_PLUS_RD, SA_I, SA_J, SA_SUM, SA_N, SA_ACC_NEW, SA_ACC
    } saddr_t;

    // S-box write data select
    typedef enum logic [1:0] {
        WD_RD, WD_SI, WD_N
    } wdata_t;

    typedef struct packed {
        jmp_t   jmp;
        upc_t   target;
        saddr_t sa;
        logic   s_re;
        logic   s_we;
        wdata_t wd;
        logic   ld_j;
        logic   ld_si;
        logic   ld_sj;
        logic   ld_acc;
        logic   clr_acc;
        logic   inc_n;
        logic   clr_ki;
        logic   adv_ki;
        logic   out_xor;
        logic   out_pass;
        logic   fin;
    } ucode_t;

    // Sequencer to datapath
    typedef struct packed {
        ucode_t mc;
        logic   take;
    } dp_ctl_t;

    // Datapath to sequencer
    typedef struct packed {
        logic s_valid;
        logic func;
        logic key_last;
        logic keyed;
        logic n_last;
        logic out_free;
    } seq_cond_t;

    function automatic ucode_t ucode_rom(input upc_t addr);
        ucode_t w;
        w        = '0;
        w.jmp    = J_NEXT;
        w.target = U_IDLE;
        w.sa     = SA_I;
        w.wd     = WD_RD;
        case (addr)
            U_IDLE: begin
                // speculative read of S[i+1] for the next data byte
                w.jmp  = J_DISPATCH;
                w.sa   = SA_I_PLUS1;
                w.s_re = 1'b1;
            end
            U_P1: begin
                w.sa    = SA_J_PLUS_RD;
                w.s_re  = 1'b1;
                w.ld_j  = 1'b1;
                w.ld_si = 1'b1;
            end
            U_P2: begin
                w.sa    = SA_I;
                w.s_we  = 1'b1;
                w.wd    = WD_RD;
                w.ld_sj = 1'b1;
            end
            U_P3: begin
                w.sa   = SA_J;
                w.s_we = 1'b1;
                w.wd   = WD_SI;
            end
            U_P4: begin
                w.sa   = SA_SUM;
                w.s_re = 1'b1;
            end
            U_P5: begin
                w.jmp     = J_WAIT_OUT;
                w.target  = U_IDLE;
                w.out_xor = 1'b1;
            end
            U_PASS: begin
                w.jmp      = J_WAIT_OUT;
                w.target   = U_IDLE;
                w.out_pass = 1'b1;
            end
            U_K0: begin
                // identity fill
                w.jmp     = J_LOOP;
                w.target  = U_K0;
                w.sa      = SA_N;
                w.s_we    = 1'b1;
                w.wd      = WD_N;
                w.inc_n   = 1'b1;
                w.clr_acc = 1'b1;
                w.clr_ki  = 1'b1;
            end
            U_K1: begin
                w.sa   = SA_N;
                w.s_re = 1'b1;
            end
            U_K2: begin
                w.sa     = SA_ACC_NEW;
                w.s_re   = 1'b1;
                w.ld_acc = 1'b1;
                w.ld_si  = 1'b1;
            end
            U_K3: begin
                w.sa   = SA_N;
                w.s_we = 1'b1;
                w.wd   = WD_RD;
            end
            U_K4: begin
                w.jmp    = J_LOOP;
                w.target = U_K1;
                w.sa     = SA_ACC;
                w.s_we   = 1'b1;
                w.wd     = WD_SI;
                w.inc_n  = 1'b1;
                w.adv_ki = 1'b1;
            end
            U_K5: begin
                w.jmp    = J_GOTO;
                w.target = U_IDLE;
                w.fin    = 1'b1;
            end
            default: begin
                w.jmp    = J_GOTO;
                w.target = U_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

@@ hw/rtl/rc4_seq.sv @@
// Microcode sequencer: step counter, control ROM lookup and jump logic.
// Depends on rc4_pkg and rc4_stream_cipher_assert.svh.
module rc4_seq (
    input  logic               aclk,
    input  logic               aresetn,
    input  rc4_pkg::seq_cond_t cond,
    output rc4_pkg::dp_ctl_t   ctl,
    output logic               s_ready
);
    import rc4_pkg::*;

    upc_t   upc_reg;
    upc_t   upc_next;
    upc_t   upc_inc;
    ucode_t mc;

    assign mc      = ucode_rom(upc_reg);
    assign upc_inc = upc_t'(upc_reg + 4'd1);
    assign s_ready = (mc.jmp == J_DISPATCH);

    always_comb begin
        ctl.mc   = mc;
        ctl.take = s_ready && cond.s_valid;
        upc_next = upc_reg;
        case (mc.jmp)
            J_NEXT: begin
                upc_next = upc_inc;
            end
            J_GOTO: begin
                upc_next = mc.target;
            end
            J_LOOP: begin
                upc_next = cond.n_last ? upc_inc : mc.target;
            end
            J_WAIT_OUT: begin
                // hold until the output register can take the result
                upc_next = cond.out_free ? mc.target : upc_reg;
            end
            J_DISPATCH: begin
                if (cond.s_valid) begin
                    if (cond.func == FUNC_KEY) begin
                        upc_next = cond.key_last ? U_K0 : U_IDLE;
                    end else begin
                        upc_next = cond.keyed ? U_P1 : U_PASS;
                    end
                end
            end
            default: begin
                upc_next = U_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= U_IDLE;
        end else begin
            upc_reg <= upc_next;
        end
    end

`include "rc4_stream_cipher_assert.svh"

    `RC4_ASSERT_NXT(a_key_last_starts_sched, ctl.take && !cond.func && cond.key_last, upc_reg == U_K0, "last key byte did not start schedule")
    `RC4_ASSERT_NXT(a_keyed_data_runs_prga, ctl.take && cond.func && cond.keyed, upc_reg == U_P1, "keyed data byte did not enter keystream step")
    `RC4_ASSERT_NXT(a_mix_loop_exit, upc_reg == U_K4 && cond.n_last, upc_reg == U_K5, "mix loop did not end after last entry")

endmodule

@@ hw/rtl/rc4_dp.sv @@
// Datapath: S-box and key memories, index registers and output register.
// Driven by rc4_seq control words; depends on rc4_pkg and the assert header.
module rc4_dp #(
    parameter int MAX_KEY_BYTES = rc4_pkg::MAX_KEY_BYTES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  rc4_pkg::rc4_in_t   s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output rc4_pkg::rc4_out_t  m_data,
    input  rc4_pkg::dp_ctl_t   ctl,
    output rc4_pkg::seq_cond_t cond
);
    import rc4_pkg::*;

    localparam int KEY_AW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;

    logic [7:0] sbox_mem [256];
    logic [7:0] key_mem  [MAX_KEY_BYTES];

    logic [7:0] s_rd_reg;
    logic [7:0] k_rd_reg;
    logic [7:0] i_reg;
    logic [7:0] j_reg;
    logic [7:0] si_reg;
    logic [7:0] sj_reg;
    logic [7:0] acc_reg;
    logic [7:0] n_reg;
    logic [7:0] byte_reg;
    logic       keyed_reg;
    logic [KEY_AW-1:0]    ki_reg;
    logic [KEY_AW-1:0]    ki_next;
    logic [KEY_CNT_W-1:0] key_cnt_reg;
    logic [KEY_CNT_W-1:0] key_cnt_next;
    logic [KEY_CNT_W-1:0] len_reg;
    logic [KEY_CNT_W-1:0] ki_inc;
    logic       m_valid_reg;
    rc4_out_t   m_data_reg;

    logic [7:0] s_addr;
    logic [7:0] s_wd;
    logic [7:0] j_new;
    logic [7:0] acc_new;
    logic       key_store;
    logic       out_load;
    logic       out_free;

    assign out_free  = !m_valid_reg || m_ready;
    assign out_load  = (ctl.mc.out_xor || ctl.mc.out_pass) && out_free;
    assign j_new     = j_reg + s_rd_reg;
    assign acc_new   = acc_reg + s_rd_reg + k_rd_reg;
    assign key_store = ctl.take && (s_data.func == FUNC_KEY)
                       && (key_cnt_reg < KEY_CNT_W'(MAX_KEY_BYTES));
    assign ki_inc    = KEY_CNT_W'(ki_reg) + KEY_CNT_W'(1);
    assign ki_next   = (ki_inc >= len_reg) ? '0 : ki_inc[KEY_AW-1:0];
    assign key_cnt_next = key_store ? key_cnt_reg + KEY_CNT_W'(1) : key_cnt_reg;

    always_comb begin
        case (ctl.mc.sa)
            SA_I_PLUS1:   s_addr = i_reg + 8'd1;
            SA_J_PLUS_RD: s_addr = j_new;
            SA_I:         s_addr = i_reg;
            SA_J:         s_addr = j_reg;
            SA_SUM:       s_addr = si_reg + sj_reg;
            SA_N:         s_addr = n_reg;
            SA_ACC_NEW:   s_addr = acc_new;
            SA_ACC:       s_addr = acc_reg;
            default:      s_addr = i_reg;
        endcase
        case (ctl.mc.wd)
            WD_RD:   s_wd = s_rd_reg;
            WD_SI:   s_wd = si_reg;
            WD_N:    s_wd = n_reg;
            default: s_wd = s_rd_reg;
        endcase
    end

    // S-box: single port, registered read, read data holds when idle
    always_ff @(posedge aclk) begin
        if (ctl.mc.s_we) begin
            sbox_mem[s_addr] <= s_wd;
        end else if (ctl.mc.s_re) begin
            s_rd_reg <= sbox_mem[s_addr];
        end
    end

    // Key buffer: written on key bytes within capacity, otherwise read at the schedule index
    always_ff @(posedge aclk) begin
        if (key_store) begin
            key_mem[key_cnt_reg[KEY_AW-1:0]] <= s_data.byte_in;
        end else begin
            k_rd_reg <= key_mem[ki_reg];
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (ctl.take) begin
            byte_reg <= s_data.byte_in;
        end
        if (ctl.take && (s_data.func == FUNC_KEY) && s_data.key_last) begin
            len_reg <= key_cnt_next;
        end
        if (ctl.mc.ld_si) begin
            si_reg <= s_rd_reg;
        end
        if (ctl.mc.ld_sj) begin
            sj_reg <= s_rd_reg;
        end
        if (ctl.mc.clr_acc) begin
            acc_reg <= '0;
        end else if (ctl.mc.ld_acc) begin
            acc_reg <= acc_new;
        end
        if (ctl.mc.clr_ki) begin
            ki_reg <= '0;
        end else if (ctl.mc.adv_ki) begin
            ki_reg <= ki_next;
        end
        if (out_load) begin
            m_data_reg.byte_out  <= ctl.mc.out_xor ? (byte_reg ^ s_rd_reg) : byte_reg;
            m_data_reg.not_keyed <= ctl.mc.out_pass;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            i_reg       <= '0;
            j_reg       <= '0;
            n_reg       <= '0;
            keyed_reg   <= 1'b0;
            key_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (ctl.mc.fin) begin
                i_reg <= '0;
                j_reg <= '0;
            end else begin
                if (ctl.take && (s_data.func == FUNC_DATA) && keyed_reg) begin
                    i_reg <= i_reg + 8'd1;
                end
                if (ctl.mc.ld_j) begin
                    j_reg <= j_new;
                end
            end
            if (ctl.mc.inc_n) begin
                n_reg <= n_reg + 8'd1;
            end
            if (ctl.mc.fin) begin
                keyed_reg <= 1'b1;
            end
            if (ctl.take && (s_data.func == FUNC_KEY)) begin
                key_cnt_reg <= s_data.key_last ? '0 : key_cnt_next;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        cond.s_valid  = s_valid;
        cond.func     = s_data.func;
        cond.key_last = s_data.key_last;
        cond.keyed    = keyed_reg;
        cond.n_last   = (n_reg == 8'hFF);
        cond.out_free = out_free;
    end

`include "rc4_stream_cipher_assert.svh"

    `RC4_ASSERT_NXT(a_keyed_sticky, keyed_reg, keyed_reg, "keyed flag dropped")
    `RC4_ASSERT_IMP(a_key_cnt_bound, 1'b1, key_cnt_reg <= KEY_CNT_W'(MAX_KEY_BYTES), "key count past buffer size")
    `RC4_ASSERT_IMP(a_out_from_ucode, $rose(m_valid_reg), $past(ctl.mc.out_xor || ctl.mc.out_pass), "result raised outside an output step")

endmodule

@@ hw/rtl/rc4_stream_cipher.sv @@
// RC4 byte stream cipher, top level: sequencer plus datapath.
// Depends on rc4_pkg, rc4_seq and rc4_dp.
//
// Send key bytes (func = 0) and flag the final one with key_last; up to
// MAX_KEY_BYTES are kept, extra bytes are dropped. The last key byte starts
// the key schedule of 256 identity fill steps, then four S-box accesses
// per entry over 256 entries, then one finish step; s_ready stays low
// meanwhile. Other key bytes are taken without leaving the idle step.
// A keyed data byte (func = 1) blocks new input until its steps are done;
// the single-port S-box makes the read of S[i], the read of S[j], the two
// swap writes and the read of S[S[i]+S[j]] go in turn before the output.
// A data byte before any key schedule comes back unchanged with not_keyed
// set. Results sit in an output register, so the next transaction is
// accepted while a result waits; the block stalls only when a second result
// is ready before the first has been taken. Key bytes give no result.
module rc4_stream_cipher #(
    parameter int MAX_KEY_BYTES = rc4_pkg::MAX_KEY_BYTES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  rc4_pkg::rc4_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output rc4_pkg::rc4_out_t m_data
);
    import rc4_pkg::*;

    dp_ctl_t   ctl;
    seq_cond_t cond;

    rc4_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cond    (cond),
        .ctl     (ctl),
        .s_ready (s_ready)
    );

    rc4_dp #(
        .MAX_KEY_BYTES (MAX_KEY_BYTES)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .ctl     (ctl),
        .cond    (cond)
    );

endmodule

@@ bench/rc4_stream_cipher_tb.sv @@
// Self-checking bench for rc4_stream_cipher: predicts the cipher output
// per accepted transaction and checks each result in order.
// Depends on rc4_pkg and the rc4_stream_cipher RTL.
module rc4_stream_cipher_tb;
    import rc4_pkg::*;

    localparam int N_ITEMS      = 1750;
    localparam int KEY_CAP      = MAX_KEY_BYTES_DEF;
    localparam int IDLE_PCT     = 18;
    localparam int QUIET_LO     = 900;
    localparam int QUIET_HI     = 1250;
    localparam int STALL_AT     = 400;
    // long enough to outlast a full key and its schedule, so data backs up
    localparam int STALL_CYCLES = 3000;
    localparam int TAIL_CYCLES  = 20;
    localparam int LIMIT_CYCLES = 600000;

    typedef struct {
        rc4_in_t tr;
        bit      drain_first;
    } stim_t;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    rc4_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    rc4_out_t m_data;

    stim_t    pending_q[$];
    rc4_out_t cipher_out_q[$];

    // cipher state as seen from outside
    logic [7:0] ks_sbox [256];
    logic [7:0] ks_key  [256];
    logic [8:0] ks_key_len = '0;
    logic [7:0] ks_i       = '0;
    logic [7:0] ks_j       = '0;
    bit         ks_keyed   = 1'b0;

    int error_count     = 0;
    int in_count        = 0;
    int pending_results = 0;
    int total_items     = 0;
    int n_schedules     = 0;
    int n_keyed_bytes   = 0;
    int n_passthru      = 0;
    int longest_key     = 0;
    int hold_cycles     = 0;
    bit stall_done      = 1'b0;
    rc4_out_t want;

    rc4_stream_cipher uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #(LIMIT_CYCLES * 10);
        $display("status: fail");
        $finish;
    end

    task automatic report_mismatch(input string what, input int exp_val, input int got_val);
        error_count++;
        $display("mismatch %0d: %s expected %0d got %0d", error_count, what, exp_val, got_val);
    endtask

    function automatic bit idle_draw();
        return (in_count < QUIET_LO || in_count >= QUIET_HI)
            && ($urandom_range(0, 99) < IDLE_PCT);
    endfunction

    task automatic rc4_rekey(input int len);
        logic [7:0] acc;
        logic [7:0] tmp;
        int kidx;
        acc  = '0;
        kidx = 0;
        for (int n = 0; n < 256; n++) ks_sbox[n] = n[7:0];
        for (int n = 0; n < 256; n++) begin
            acc = acc + ks_sbox[n] + ks_key[kidx];
            tmp = ks_sbox[n];
            ks_sbox[n] = ks_sbox[acc];
            ks_sbox[acc] = tmp;
            kidx++;
            if (kidx >= len) kidx = 0;
        end
        ks_i     = '0;
        ks_j     = '0;
        ks_keyed = 1'b1;
        if (len > longest_key) longest_key = len;
        n_schedules++;
    endtask

    task automatic rc4_absorb(input rc4_in_t t);
        logic [7:0] tmp;
        rc4_out_t   r;
        if (t.func == FUNC_KEY) begin
            // drop key bytes past the buffer, but still honor the last flag
            if (ks_key_len < KEY_CAP) begin
                ks_key[ks_key_len[7:0]] = t.byte_in;
                ks_key_len++;
            end
            if (t.key_last) begin
                rc4_rekey(int'(ks_key_len));
                ks_key_len = '0;
            end
        end else if (!ks_keyed) begin
            r.byte_out  = t.byte_in;
            r.not_keyed = 1'b1;
            cipher_out_q.push_back(r);
            n_passthru++;
        end else begin
            ks_i = ks_i + 8'd1;
            ks_j = ks_j + ks_sbox[ks_i];
            tmp = ks_sbox[ks_i];
            ks_sbox[ks_i] = ks_sbox[ks_j];
            ks_sbox[ks_j] = tmp;
            r.byte_out  = t.byte_in ^ ks_sbox[8'(ks_sbox[ks_i] + ks_sbox[ks_j])];
            r.not_keyed = 1'b0;
            cipher_out_q.push_back(r);
            n_keyed_bytes++;
        end
    endtask

    task automatic queue_item(input logic func, input logic [7:0] b, input logic last,
                              input bit drain);
        stim_t s;
        s.tr.func     = func;
        s.tr.byte_in  = b;
        s.tr.key_last = last;
        s.drain_first = drain;
        pending_q.push_back(s);
    endtask

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // driver: advance only after the current transaction is taken
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (pending_q.size() != 0 && !idle_draw()
                    && !(pending_q[0].drain_first && (s_valid || pending_results != 0))) begin
                s_data  <= pending_q[0].tr;
                s_valid <= 1'b1;
                void'(pending_q.pop_front());
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver: random backpressure plus one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_cycles > 0) begin
            m_ready     <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else if (!stall_done && in_count >= STALL_AT) begin
            m_ready     <= 1'b0;
            hold_cycles <= STALL_CYCLES;
            stall_done  <= 1'b1;
        end else begin
            m_ready <= !idle_draw();
        end
    end

    // monitor: check results first, then fold in the accepted input
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (cipher_out_q.size() == 0) begin
                    report_mismatch("unexpected result byte_out", -1,
                                    int'(m_data.byte_out));
                end else begin
                    want = cipher_out_q.pop_front();
                    if (m_data.byte_out !== want.byte_out)
                        report_mismatch("byte_out", int'(want.byte_out),
                                        int'(m_data.byte_out));
                    if (m_data.not_keyed !== want.not_keyed)
                        report_mismatch("not_keyed", int'(want.not_keyed),
                                        int'(m_data.not_keyed));
                end
            end
            if (s_valid && s_ready) begin
                rc4_absorb(s_data);
                in_count <= in_count + 1;
            end
            pending_results <= cipher_out_q.size();
        end
    end

    initial begin
        int pick;
        int len;
        int seq_no;
        int n_data;

        // data before any key: pass through
        queue_item(FUNC_DATA, 8'h00, 1'b0, 1'b0);
        queue_item(FUNC_DATA, 8'hFF, 1'b1, 1'b0);
        queue_item(FUNC_DATA, 8'hA5, 1'b0, 1'b0);
        // one-byte key
        queue_item(FUNC_KEY, 8'h00, 1'b1, 1'b0);
        queue_item(FUNC_DATA, 8'h00, 1'b0, 1'b0);
        queue_item(FUNC_DATA, 8'hFF, 1'b0, 1'b0);
        queue_item(FUNC_DATA, 8'hFF, 1'b0, 1'b0);
        // three-byte key, then text
        queue_item(FUNC_KEY, 8'h4B, 1'b0, 1'b0);
        queue_item(FUNC_KEY, 8'h65, 1'b0, 1'b0);
        queue_item(FUNC_KEY, 8'h79, 1'b1, 1'b0);
        queue_item(FUNC_DATA, 8'h50, 1'b0, 1'b0);
        queue_item(FUNC_DATA, 8'h6C, 1'b0, 1'b0);
        queue_item(FUNC_DATA, 8'h61, 1'b0, 1'b0);
        queue_item(FUNC_DATA, 8'h69, 1'b0, 1'b0);
        // next key loads while the current S-box keeps running
        queue_item(FUNC_KEY, 8'hFF, 1'b0, 1'b0);
        queue_item(FUNC_DATA, 8'h12, 1'b0, 1'b0);
        queue_item(FUNC_KEY, 8'h80, 1'b0, 1'b0);
        queue_item(FUNC_DATA, 8'h77, 1'b1, 1'b0);
        queue_item(FUNC_KEY, 8'h01, 1'b1, 1'b0);
        queue_item(FUNC_DATA, 8'h34, 1'b0, 1'b0);
        queue_item(FUNC_DATA, 8'hFF, 1'b1, 1'b0);

        seq_no = 0;
        while (pending_q.size() < N_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (seq_no == 3)
                len = KEY_CAP + 1;
            else if (seq_no == 7)
                len = KEY_CAP;
            else if ($urandom_range(0, 19) == 0)
                len = $urandom_range(17, 300);
            else
                len = $urandom_range(1, 16);

            if (pick < 72 || seq_no < 8) begin
                for (int k = 0; k < len; k++)
                    queue_item(FUNC_KEY, rand_byte(), k == len - 1,
                               k == 0 && (seq_no == 5 || $urandom_range(0, 5) == 0));
                n_data = $urandom_range(10, 70);
                for (int k = 0; k < n_data; k++)
                    queue_item(FUNC_DATA, rand_byte(), $urandom_range(0, 7) == 0, 1'b0);
            end else if (pick < 87) begin
                // key bytes mixed into a running stream
                for (int k = 0; k < len; k++) begin
                    queue_item(FUNC_KEY, rand_byte(), k == len - 1, 1'b0);
                    if ($urandom_range(0, 1) == 1) begin
                        n_data = $urandom_range(1, 4);
                        for (int d = 0; d < n_data; d++)
                            queue_item(FUNC_DATA, rand_byte(), 1'b0, 1'b0);
                    end
                end
            end else begin
                n_data = $urandom_range(4, 12);
                for (int k = 0; k < n_data; k++)
                    queue_item(logic'($urandom_range(0, 1)), rand_byte(),
                               $urandom_range(0, 7) == 0, 1'b0);
            end
            seq_no++;
        end
        total_items = pending_q.size();

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        while (in_count != total_items) @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (cipher_out_q.size() != 0)
            report_mismatch("results never returned", 0, cipher_out_q.size());

        $display("ran %0d transactions: %0d key schedules (longest key %0d bytes)",
                 in_count, n_schedules, longest_key);
        $display("checked %0d keyed bytes and %0d bytes sent before any key",
                 n_keyed_bytes, n_passthru);
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
